// File: rtl/core/ifbs_pkg.sv
// Shared types and constants for the information frame byte stuffer.
package ifbs_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7e;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7d;
    localparam logic [7:0] ESC_TOGGLE  = 8'h20;

    localparam logic [7:0] ADDRESS_RESET = 8'h03;
    localparam logic [7:0] CONTROL_RESET = 8'h40;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL = 2'd1;

    typedef enum logic [3:0] {
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_HCHK,
        PH_DATA,
        PH_DATA_ESC,
        PH_CHK,
        PH_CHK_ESC,
        PH_CLOSE
    } t_phase;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
        logic       frame_done;
    } t_beat;

    function automatic logic needs_escape(input logic [7:0] b);
        needs_escape = (b == FLAG_BYTE) || (b == ESCAPE_BYTE);
    endfunction

endpackage

// File: rtl/core/info_frame_byte_stuffer_core.sv
// Top level of the information frame byte stuffer.
//
//  channel   direction  tdata                    tlast       tuser
//  s_axis    in         [7:0] data_byte          packet_end  -
//  m_axis    out        [7:0] line_byte          run_last    frame_done
//  cfg       in         index 0 address, 1 control, plain write
//
// An input beat becomes 1 or 2 output bytes inside a frame, up to 9 for a one-byte
// packet (4 header, 2 data, 2 check, 1 flag); the sequencer emits one byte per cycle
// while m_axis is not stalled. The next beat is taken in the cycle its predecessor's
// last byte moves to the output register. Reset is synchronous and closes any frame.
// A stall on m_axis holds the output register and back-pressures s_axis.
module info_frame_byte_stuffer_core import ifbs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] line_byte
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser,   // [0] frame_done
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    logic [7:0] r_address;
    logic [7:0] r_control;
    t_beat      seq_beat;
    logic       seq_valid;
    logic       seq_ready;
    t_beat      out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= ADDRESS_RESET;
            r_control <= CONTROL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ADDRESS: r_address <= i_cfg_data;
                CFG_CONTROL: r_control <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ifbs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .i_address    (r_address),
        .i_control    (r_control),
        .o_beat       (seq_beat),
        .o_beat_valid (seq_valid),
        .i_beat_ready (seq_ready)
    );

    ifbs_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (seq_beat),
        .i_beat_valid (seq_valid),
        .o_beat_ready (seq_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_beat       (out_beat)
    );

    assign m_axis_tdata = out_beat.line_byte;
    assign m_axis_tlast = out_beat.run_last;
    assign m_axis_tuser = out_beat.frame_done;

endmodule

// File: rtl/core/ifbs_seq.sv
// Item register and byte sequencer: header, stuffed data, stuffed check, closing flag.
module ifbs_seq import ifbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_data,
    input  logic       i_in_last,
    output logic       o_in_ready,
    input  logic [7:0] i_address,
    input  logic [7:0] i_control,
    output t_beat      o_beat,
    output logic       o_beat_valid,
    input  logic       i_beat_ready
);

    logic       r_busy;
    t_phase     r_phase;
    logic [7:0] r_data;
    logic       r_last;
    logic [7:0] r_sum;
    logic       r_inside;
    logic [7:0] r_check;

    t_phase     n_phase;
    logic       step_done;
    logic       emit;
    logic       accept;
    logic [7:0] check_base;

    assign emit       = r_busy & i_beat_ready;
    assign o_in_ready = ~r_busy | (emit & step_done);
    assign accept     = i_in_valid & o_in_ready;
    assign check_base = r_inside ? r_check : 8'h00;
    assign o_beat_valid = r_busy;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_FLAG:     n_phase = PH_ADDR;
            PH_ADDR:     n_phase = PH_CTRL;
            PH_CTRL:     n_phase = PH_HCHK;
            PH_HCHK:     n_phase = PH_DATA;
            PH_DATA:     n_phase = needs_escape(r_data) ? PH_DATA_ESC : PH_CHK;
            PH_DATA_ESC: n_phase = PH_CHK;
            PH_CHK:      n_phase = needs_escape(r_sum) ? PH_CHK_ESC : PH_CLOSE;
            PH_CHK_ESC:  n_phase = PH_CLOSE;
            PH_CLOSE:    n_phase = PH_CLOSE;
            default:     n_phase = PH_FLAG;
        endcase
    end

    always_comb begin
        o_beat.line_byte  = FLAG_BYTE;
        o_beat.frame_done = 1'b0;
        step_done         = 1'b0;
        unique case (r_phase)
            PH_FLAG:     o_beat.line_byte = FLAG_BYTE;
            PH_ADDR:     o_beat.line_byte = i_address;
            PH_CTRL:     o_beat.line_byte = i_control;
            PH_HCHK:     o_beat.line_byte = i_address ^ i_control;
            PH_DATA: begin
                if (needs_escape(r_data)) begin
                    o_beat.line_byte = ESCAPE_BYTE;
                end else begin
                    o_beat.line_byte = r_data;
                    step_done        = ~r_last;
                end
            end
            PH_DATA_ESC: begin
                o_beat.line_byte = r_data ^ ESC_TOGGLE;
                step_done        = ~r_last;
            end
            PH_CHK:      o_beat.line_byte = needs_escape(r_sum) ? ESCAPE_BYTE : r_sum;
            PH_CHK_ESC:  o_beat.line_byte = r_sum ^ ESC_TOGGLE;
            PH_CLOSE: begin
                o_beat.line_byte  = FLAG_BYTE;
                o_beat.frame_done = 1'b1;
                step_done         = 1'b1;
            end
            default:     o_beat.line_byte = FLAG_BYTE;
        endcase
        o_beat.run_last = step_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_FLAG;
            r_inside <= 1'b0;
            r_check  <= 8'h00;
        end else if (accept) begin
            r_busy   <= 1'b1;
            r_phase  <= r_inside ? PH_DATA : PH_FLAG;
            r_inside <= ~i_in_last;
            r_check  <= i_in_last ? 8'h00 : (check_base ^ i_in_data);
        end else if (emit) begin
            if (step_done) begin
                r_busy <= 1'b0;
            end else begin
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_in_data;
            r_last <= i_in_last;
            r_sum  <= check_base ^ i_in_data;
        end
    end

endmodule

// File: rtl/core/ifbs_obuf.sv
// Output register stage for the line byte stream.
module ifbs_obuf import ifbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_beat      i_beat,
    input  logic       i_beat_valid,
    output logic       o_beat_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output t_beat      o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_beat_ready = ~r_valid | i_ready;
    assign o_valid      = r_valid;
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_beat_ready) begin
            r_valid <= i_beat_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_beat_ready && i_beat_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

// File: rtl/core/ifbs_checker.sv
// Port-level checker for the byte stuffer top level, with its bind.
module ifbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("m_axis payload changed while stalled");

    a_close_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h7e && m_axis_tlast)
        else $error("frame end is not a closing flag ending the beat");

    a_flag_last_is_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata == 8'h7e |-> m_axis_tuser)
        else $error("unstuffed flag byte ends a beat outside the closing flag");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("m_axis valid right after reset");

endmodule

bind info_frame_byte_stuffer_core ifbs_checker u_ifbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
